@@ rtl/rfc_pkg.sv @@
`default_nettype none
package rfc_pkg;

  localparam int ADDR_CHARS = 8;
  localparam int CFG_W      = 64;
  localparam int LEN_W      = 4;
  localparam int POS_W      = 4;
  localparam int SUM_W      = 7;

  localparam logic [7:0]       CH_START = 8'h3E;
  localparam logic [7:0]       CH_STAR  = 8'h2A;
  localparam logic [7:0]       CH_SLASH = 8'h2F;
  localparam logic [7:0]       CH_CR    = 8'h0D;
  localparam logic [7:0]       CH_LF    = 8'h0A;
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  typedef enum logic [0:0] {
    KIND_BYTE  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_ADDRESS_LENGTH = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CHECK = 2'd1,
    ST_ADDR     = 2'd2,
    ST_SUM      = 2'd3
  } status_t;

  typedef struct packed {
    logic             in_frame;
    logic             cr_pending;
    logic [SUM_W-1:0] running_sum;
    logic [SUM_W-1:0] sum_at_star;
    logic             star_seen;
    logic             byte_after_star_valid;
    logic [7:0]       byte_after_star;
    logic [POS_W-1:0] char_position;
    logic             slash_seen;
    logic             slash_before_star;
    logic             prefix_match;
    logic             address_match;
  } frame_st_t;

  typedef struct packed {
    logic             accepted;
    status_t          status;
    logic [SUM_W-1:0] computed_checksum;
  } result_t;

  typedef struct packed {
    logic fire;
    logic in_frame;
  } core_stat_t;

  localparam frame_st_t FRAME_CLEAR = '{
    in_frame: 1'b0, cr_pending: 1'b0, running_sum: '0, sum_at_star: '0,
    star_seen: 1'b0, byte_after_star_valid: 1'b0, byte_after_star: '0,
    char_position: '0, slash_seen: 1'b0, slash_before_star: 1'b0,
    prefix_match: 1'b1, address_match: 1'b0};

  // One body byte: address prefix tracking, star bookkeeping and the running sum.
  function automatic frame_st_t frame_data(frame_st_t s, logic [7:0] b,
                                           logic [CFG_W-1:0] addr,
                                           logic [LEN_W-1:0] len);
    frame_st_t  t;
    logic       ok;
    logic [7:0] want;
    t    = s;
    ok   = 1'b0;
    want = '0;
    for (int i = 0; i < ADDR_CHARS; i++) begin
      if (s.char_position == POS_W'(i)) begin
        want = addr[8*i +: 8];
      end
    end
    if (!s.slash_seen) begin
      if (b == CH_SLASH) begin
        t.slash_seen    = 1'b1;
        t.address_match = s.prefix_match && (s.char_position == len);
      end else begin
        ok = (s.char_position < POS_W'(ADDR_CHARS)) && (s.char_position < len) &&
             (want == b);
        if (!ok) begin
          t.prefix_match = 1'b0;
        end
        if (s.char_position != POS_MAX) begin
          t.char_position = s.char_position + 1'b1;
        end
      end
    end
    if (b == CH_STAR) begin
      t.sum_at_star           = s.running_sum + b[SUM_W-1:0];
      t.star_seen             = 1'b1;
      t.byte_after_star_valid = 1'b0;
      if (t.slash_seen) begin
        t.slash_before_star = 1'b1;
      end
    end else if (s.star_seen && !s.byte_after_star_valid) begin
      t.byte_after_star_valid = 1'b1;
      t.byte_after_star       = b;
    end
    t.running_sum = s.running_sum + b[SUM_W-1:0];
    return t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rfc_in_reg.sv @@
`default_nettype none
module rfc_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          slot_free,
  output logic               item_v,
  output rfc_pkg::kind_t     item_kind,
  output logic [7:0]         item_byte
);
  import rfc_pkg::*;

  logic       item_v_r;
  kind_t      kind_r;
  logic [7:0] byte_r;

  // The held transaction leaves only when the result side has room.
  assign in_stall = item_v_r && !slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (!in_stall) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r <= kind_t'(in_kind);
      byte_r <= in_data_byte;
    end
  end

  assign item_v    = item_v_r;
  assign item_kind = kind_r;
  assign item_byte = byte_r;
endmodule
`default_nettype wire

@@ rtl/rfc_frame_core.sv @@
`default_nettype none
module rfc_frame_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire rfc_pkg::kind_t              item_kind,
  input  wire logic [7:0]                  item_byte,
  input  wire logic [rfc_pkg::CFG_W-1:0]   dev_addr,
  input  wire logic [rfc_pkg::LEN_W-1:0]   addr_len,
  output rfc_pkg::result_t                 result,
  output rfc_pkg::core_stat_t              stat
);
  import rfc_pkg::*;

  frame_st_t frame_r;
  frame_st_t frame_nxt;
  frame_st_t body;
  logic      close;
  logic      addr_ok;
  status_t   status;

  always_comb begin
    body      = frame_r;
    close     = 1'b0;
    frame_nxt = frame_r;
    priority if (item_kind == KIND_CLEAR) begin
      frame_nxt = FRAME_CLEAR;
    end else if (!frame_r.in_frame) begin
      if (item_byte == CH_START) begin
        frame_nxt             = FRAME_CLEAR;
        frame_nxt.in_frame    = 1'b1;
        frame_nxt.running_sum = CH_START[SUM_W-1:0];
      end
    end else if (frame_r.cr_pending && item_byte == CH_LF) begin
      close     = 1'b1;
      frame_nxt = FRAME_CLEAR;
    end else begin
      // A CR without LF behind it is ordinary data, ahead of this byte.
      if (frame_r.cr_pending) begin
        body            = frame_data(frame_r, CH_CR, dev_addr, addr_len);
        body.cr_pending = 1'b0;
      end
      if (item_byte == CH_CR) begin
        body.cr_pending = 1'b1;
      end else begin
        body = frame_data(body, item_byte, dev_addr, addr_len);
      end
      frame_nxt = body;
    end
  end

  always_comb begin
    addr_ok = frame_r.slash_before_star ? frame_r.address_match : (addr_len == '0);
    priority if (!frame_r.star_seen || !frame_r.byte_after_star_valid) begin
      status = ST_NO_CHECK;
    end else if (!addr_ok) begin
      status = ST_ADDR;
    end else if ({1'b0, frame_r.sum_at_star} != frame_r.byte_after_star) begin
      status = ST_SUM;
    end else begin
      status = ST_OK;
    end
    result.accepted          = (status == ST_OK);
    result.status            = status;
    result.computed_checksum = frame_r.star_seen ? frame_r.sum_at_star : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= FRAME_CLEAR;
    end else if (step) begin
      frame_r <= frame_nxt;
    end
  end

  assign stat.fire     = step && close;
  assign stat.in_frame = frame_r.in_frame;
endmodule
`default_nettype wire

@@ rtl/rfc_out_reg.sv @@
`default_nettype none
module rfc_out_reg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire rfc_pkg::result_t           result,
  output logic                            slot_free,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_accepted,
  output logic [1:0]                      out_status,
  output logic [rfc_pkg::SUM_W-1:0]       out_computed_checksum
);
  import rfc_pkg::*;

  logic    out_v_r;
  logic    out_v_nxt;
  result_t res_r;

  assign slot_free = !out_v_r || !out_stall;

  always_comb begin
    priority if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_stall) begin
      out_v_nxt = out_v_r;
    end else begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid             = out_v_r;
  assign out_accepted          = res_r.accepted;
  assign out_status            = res_r.status;
  assign out_computed_checksum = res_r.computed_checksum;
endmodule
`default_nettype wire

@@ rtl/reply_frame_checker_core.sv @@
`default_nettype none
// Channel  | Ports                                                    | Direction
// ---------+----------------------------------------------------------+----------
// input    | in_valid, in_stall, in_kind, in_data_byte                | in
// result   | out_valid, out_stall, out_accepted, out_status,          | out
//          | out_computed_checksum                                    |
// config   | cfg_we, cfg_index, cfg_wdata                             | in
//
// One item per cycle while in_stall is low: an item is held in the input
// register, the frame update runs between that register and the frame state,
// and a frame close loads the result register, from which the result is sent.
// Reset (synchronous, rst_n low) clears the frame state and both valid flags.
// A stalled result holds its register; the input side stalls only when an item
// waits and the result register is full and stalled.
module reply_frame_checker_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_kind,
  input  wire logic [7:0]                  in_data_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_accepted,
  output logic [1:0]                       out_status,
  output logic [rfc_pkg::SUM_W-1:0]        out_computed_checksum,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [rfc_pkg::CFG_W-1:0]   cfg_wdata
);
  import rfc_pkg::*;

  logic [CFG_W-1:0] dev_addr_r;
  logic [LEN_W-1:0] addr_len_r;
  logic             slot_free;
  logic             item_v;
  kind_t            item_kind;
  logic [7:0]       item_byte;
  logic             step;
  result_t          result;
  core_stat_t       stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
      addr_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_wdata;
        CFG_ADDRESS_LENGTH: addr_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign step = item_v && slot_free;

  rfc_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .slot_free    (slot_free),
    .item_v       (item_v),
    .item_kind    (item_kind),
    .item_byte    (item_byte)
  );

  rfc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item_kind (item_kind),
    .item_byte (item_byte),
    .dev_addr  (dev_addr_r),
    .addr_len  (addr_len_r),
    .result    (result),
    .stat      (stat)
  );

  rfc_out_reg u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (stat.fire),
    .result                (result),
    .slot_free             (slot_free),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_status            (out_status),
    .out_computed_checksum (out_computed_checksum)
  );

  // A result comes only from an open frame, and closing it reopens the hunt.
  a_fire_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire |-> stat.in_frame)
    else $error("result produced outside a frame");

  a_close_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire |=> !stat.in_frame)
    else $error("frame still open after its close");

  // A held item must not be lost or changed while the result side is blocked.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v && !slot_free) |=> (item_v && $stable(item_kind) && $stable(item_byte)))
    else $error("input register lost a blocked transaction");

  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire |=> out_valid)
    else $error("result transaction did not reach the output register");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTINGS_USED = 8;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } reply_item_t;

  typedef struct packed {
    logic             ok;
    status_t          code;
    logic [SUM_W-1:0] sum;
  } frame_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = KIND_BYTE;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  logic [1:0]           out_status;
  logic [SUM_W-1:0]     out_computed_checksum;
  logic                 cfg_we = 1'b0;
  cfg_index_t           cfg_index = CFG_DEVICE_ADDRESS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Register copies used by the frame predictor.
  logic [CFG_W-1:0]     dev_addr = '0;
  logic [LEN_W-1:0]     addr_len = '0;

  // Frame predictor state.
  logic                 fr_open, fr_cr_held, fr_star, fr_check_valid;
  logic                 fr_slash, fr_slash_at_star, fr_prefix_ok, fr_addr_ok;
  logic [SUM_W-1:0]     fr_sum, fr_star_sum;
  logic [7:0]           fr_check_byte;
  logic [POS_W-1:0]     fr_pos;

  reply_item_t    pending_items[$];
  frame_verdict_t expected_verdicts[$];

  int n_pushed = 0;
  int n_taken = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int idle_pct = 10;
  int stall_pct = 10;
  int status_seen[4] = '{0, 0, 0, 0};
  int hold_left = 0;
  bit hold_off_go = 1'b0;
  bit hold_off_started = 1'b0;
  bit sender_hold = 1'b0;

  reply_frame_checker_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_kind               (in_kind),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_status            (out_status),
    .out_computed_checksum (out_computed_checksum),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic frame_restart();
    fr_open          = 1'b0;
    fr_cr_held       = 1'b0;
    fr_sum           = '0;
    fr_star_sum      = '0;
    fr_star          = 1'b0;
    fr_check_valid   = 1'b0;
    fr_check_byte    = '0;
    fr_pos           = '0;
    fr_slash         = 1'b0;
    fr_slash_at_star = 1'b0;
    fr_prefix_ok     = 1'b1;
    fr_addr_ok       = 1'b0;
  endtask

  task automatic frame_body_byte(input logic [7:0] b);
    logic [7:0] want;
    want = 8'(dev_addr >> (8 * fr_pos));
    if (!fr_slash) begin
      if (b == CH_SLASH) begin
        fr_slash   = 1'b1;
        fr_addr_ok = fr_prefix_ok && (fr_pos == addr_len);
      end else begin
        if (!(fr_pos < ADDR_CHARS && fr_pos < addr_len && want == b)) begin
          fr_prefix_ok = 1'b0;
        end
        if (fr_pos != POS_MAX) begin
          fr_pos = fr_pos + 1'b1;
        end
      end
    end
    if (b == CH_STAR) begin
      fr_star_sum    = fr_sum + b[SUM_W-1:0];
      fr_star        = 1'b1;
      fr_check_valid = 1'b0;
      if (fr_slash) begin
        fr_slash_at_star = 1'b1;
      end
    end else if (fr_star && !fr_check_valid) begin
      fr_check_valid = 1'b1;
      fr_check_byte  = b;
    end
    fr_sum = fr_sum + b[SUM_W-1:0];
  endtask

  // Advances the predictor by one accepted transaction and queues the verdict
  // of any frame it closes.
  task automatic track_reply_item(input kind_t k, input logic [7:0] b);
    frame_verdict_t v;
    logic           addr_good;
    if (k == KIND_CLEAR) begin
      frame_restart();
    end else if (!fr_open) begin
      if (b == CH_START) begin
        frame_restart();
        fr_open = 1'b1;
        fr_sum  = CH_START[SUM_W-1:0];
      end
    end else if (fr_cr_held && b == CH_LF) begin
      addr_good = fr_slash_at_star ? fr_addr_ok : (addr_len == 0);
      if (!fr_star || !fr_check_valid) begin
        v.code = ST_NO_CHECK;
      end else if (!addr_good) begin
        v.code = ST_ADDR;
      end else if ({1'b0, fr_star_sum} != fr_check_byte) begin
        v.code = ST_SUM;
      end else begin
        v.code = ST_OK;
      end
      v.ok  = (v.code == ST_OK);
      v.sum = fr_star ? fr_star_sum : '0;
      expected_verdicts.push_back(v);
      frame_restart();
    end else begin
      // A CR that is not followed by LF turns into an ordinary body byte.
      if (fr_cr_held) begin
        fr_cr_held = 1'b0;
        frame_body_byte(CH_CR);
      end
      if (b == CH_CR) begin
        fr_cr_held = 1'b1;
      end else begin
        frame_body_byte(b);
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_items.push_back('{KIND_BYTE, b});
    n_pushed++;
  endtask

  task automatic push_clear();
    pending_items.push_back('{KIND_CLEAR, 8'($urandom_range(255))});
    n_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic push_counted(input logic [7:0] b, inout logic [SUM_W-1:0] sum);
    push_byte(b);
    sum = sum + b[SUM_W-1:0];
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CH_CR || b == CH_STAR);
    return b;
  endfunction

  function automatic logic [CFG_W-1:0] printable_address();
    logic [CFG_W-1:0] a;
    for (int i = 0; i < ADDR_CHARS; i++) begin
      a[8*i +: 8] = 8'($urandom_range(8'h7E, 8'h30));
    end
    return a;
  endfunction

  // Mostly well-formed frames: the configured address, sometimes with a bad
  // character or replaced by random text, a body with zero to two stars, a
  // check byte that is usually right, and a few bytes before CR LF.
  task automatic push_random_frame();
    int               mode;
    int               n_addr;
    int               stars;
    logic [7:0]       b;
    logic [SUM_W-1:0] sum;
    sum = '0;
    push_counted(CH_START, sum);
    mode = $urandom_range(99);
    if (mode < 75) begin
      n_addr = (addr_len > ADDR_CHARS) ? ADDR_CHARS : int'(addr_len);
    end else begin
      n_addr = $urandom_range(9);
    end
    for (int i = 0; i < n_addr; i++) begin
      b = (mode < 75) ? dev_addr[8*i +: 8] : 8'($urandom_range(8'h7E, 8'h30));
      if (mode >= 60 && mode < 75 && i == n_addr - 1) begin
        b = b ^ 8'h01;
      end
      push_counted(b, sum);
    end
    if ($urandom_range(99) < 85) begin
      push_counted(CH_SLASH, sum);
    end
    stars = ($urandom_range(99) < 8) ? 0 : (($urandom_range(99) < 15) ? 2 : 1);
    for (int s = 0; s < stars || (s == 0 && stars == 0); s++) begin
      repeat ($urandom_range(4)) begin
        if ($urandom_range(19) == 0) begin
          push_counted(CH_CR, sum);
          push_counted(8'($urandom_range(8'h7E, 8'h30)), sum);
        end else begin
          push_counted(body_byte(), sum);
        end
      end
      if (stars != 0) begin
        push_counted(CH_STAR, sum);
      end
    end
    if (stars != 0 && $urandom_range(99) < 95) begin
      if ($urandom_range(99) < 80) begin
        push_byte({1'b0, sum});
      end else begin
        push_byte(8'($urandom_range(255)));
      end
      repeat ($urandom_range(2)) begin
        push_byte(body_byte());
      end
    end
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_noise();
    case ($urandom_range(2))
      0: begin
        repeat ($urandom_range(1, 4)) begin
          push_byte(8'($urandom_range(255)));
        end
      end
      1: begin
        push_clear();
      end
      default: begin
        push_byte(CH_START);
        repeat ($urandom_range(3)) begin
          push_byte(body_byte());
        end
        push_clear();
      end
    endcase
  endtask

  task automatic random_phase(input int count);
    int target;
    target = n_pushed + count;
    while (n_pushed < target) begin
      if ($urandom_range(99) < 85) begin
        push_random_frame();
      end else begin
        push_noise();
      end
    end
  endtask

  task automatic write_config(input logic [CFG_W-1:0] addr, input logic [LEN_W-1:0] len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= CFG_ADDRESS_LENGTH;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    dev_addr = addr;
    addr_len = len;
  endtask

  // Every transaction taken and every frame verdict seen, plus a final wait
  // for bytes that close no frame to work through the pipeline.
  task automatic wait_idle();
    while (n_taken != n_pushed || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int mark;
    frame_restart();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty address expected: good frame, frame without a star, a check byte
    // with bit 7 set, a clear in the middle of a frame, a nested start with
    // CR as data and bytes after the check byte, and a bad address together
    // with a bad checksum.
    write_config('0, '0);
    push_text(">*h\r\n");
    push_text(">\r\n");
    push_text(">*");
    push_byte(8'hE8);
    push_text("\r\n");
    push_text(">");
    push_clear();
    push_text("*");
    push_text(">/>*U\rx\r\n");
    push_text(">A/*");
    push_byte(8'h00);
    push_text("\r\n");
    wait_idle();

    // The receiver holds off long enough for the block to stall its input.
    write_config(printable_address(), 4'd3);
    mark = n_taken;
    random_phase(150);
    wait (n_taken > mark + 40);
    hold_off_go = 1'b1;
    wait_idle();

    idle_pct  = 0;
    stall_pct = 0;
    write_config('1, 4'd8);
    random_phase(150);
    wait_idle();
    idle_pct  = 10;
    stall_pct = 10;

    // The sender stops mid-stream until every outstanding verdict is back.
    write_config(printable_address(), 4'd8);
    mark = n_taken;
    random_phase(150);
    wait (n_taken > mark + 60);
    sender_hold = 1'b1;
    while (in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    sender_hold = 1'b0;
    wait_idle();

    // A length beyond the address register can never match a real address.
    write_config(printable_address(), 4'd12);
    random_phase(100);
    wait_idle();

    write_config(printable_address(), 4'd1);
    random_phase(150);
    wait_idle();

    write_config(printable_address(), LEN_W'($urandom_range(ADDR_CHARS)));
    random_phase(150);
    wait_idle();

    write_config('0, '0);
    random_phase(100);
    wait_idle();
    repeat (4) @(posedge clk);

    $display("Ran %0d input transactions under %0d address settings, with clears, noise,",
             n_taken, SETTINGS_USED);
    $display("a long output stall and a sender pause; frames: %0d ok, %0d no check byte,",
             status_seen[ST_OK], status_seen[ST_NO_CHECK]);
    $display("%0d bad address, %0d bad checksum.",
             status_seen[ST_ADDR], status_seen[ST_SUM]);
    if (errors == 0) begin
      $display("reply_frame_checker_core test passed");
    end else begin
      $display("reply_frame_checker_core test failed");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    reply_item_t item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        track_reply_item(kind_t'(in_kind), in_data_byte);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !sender_hold && $urandom_range(99) >= idle_pct) begin
          item = pending_items.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= item.kind;
          in_data_byte <= item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_verdict_t v;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected frame result: status %0d, accepted %0d, checksum 0x%02h",
                 $time, out_status, out_accepted, out_computed_checksum);
        errors++;
      end else begin
        v = expected_verdicts.pop_front();
        status_seen[v.code]++;
        if (out_accepted !== v.ok) begin
          $display("%0t: accepted mismatch: expected %0d, actual %0d",
                   $time, v.ok, out_accepted);
          errors++;
        end
        if (out_status !== v.code) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, v.code, out_status);
          errors++;
        end
        if (out_computed_checksum !== v.sum) begin
          $display("%0t: checksum mismatch: expected 0x%02h, actual 0x%02h",
                   $time, v.sum, out_computed_checksum);
          errors++;
        end
      end
    end
    if (hold_off_go && !hold_off_started) begin
      hold_off_started = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("reply_frame_checker_core test failed");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

@@ reply_frame_checker_core.f @@
rtl/rfc_pkg.sv
rtl/rfc_in_reg.sv
rtl/rfc_frame_core.sv
rtl/rfc_out_reg.sv
rtl/reply_frame_checker_core.sv
test/testbench.sv
